// ===== rtl/chri_pkg.sv =====
`default_nettype none

package chri_pkg;

  // program cache window geometry
  localparam int unsigned CACHE_BYTES = 512;
  localparam int unsigned CACHE_IDX_W = $clog2(CACHE_BYTES);
  localparam int unsigned NUM_LINES   = 32;
  localparam int unsigned LINE_W      = $clog2(NUM_LINES);

  // host address map, after masking
  localparam logic [15:0] ADDR_MASK      = 16'h33FF;
  localparam logic [15:0] REG_FIRST      = 16'h3000;
  localparam logic [15:0] REG_LAST       = 16'h301F;
  localparam logic [15:0] ADDR_STATUS_LO = 16'h3030;
  localparam logic [15:0] ADDR_STATUS_HI = 16'h3031;
  localparam logic [15:0] ADDR_BANK      = 16'h3034;
  localparam logic [15:0] ADDR_SCREEN    = 16'h3038;
  localparam logic [15:0] ADDR_CLKSEL    = 16'h3039;
  localparam logic [15:0] ADDR_MODE      = 16'h303A;
  localparam logic [15:0] ADDR_VERSION   = 16'h303B;
  localparam logic [15:0] WIN_BASE       = 16'h3100;
  localparam logic [15:0] WIN_LAST       = 16'h32FF;

  localparam logic [7:0] VERSION_VAL = 8'h04;

  // general register numbers with side effects
  localparam logic [3:0] REG_ROM_FETCH = 4'd14;
  localparam logic [3:0] REG_GO        = 4'd15;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_WRITE     = 2'd1,
    OP_FILL_DONE = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  // one host access, address already masked
  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  // result item, lowest field last so it packs from bit 0 up
  typedef struct packed {
    logic [7:0]           screen_base;
    logic                 clock_select;
    logic [6:0]           program_bank;
    logic                 rom_granted;
    logic                 ram_granted;
    logic [1:0]           screen_height;
    logic [3:0]           plot_bpp;
    logic [NUM_LINES-1:0] valid_lines;
    logic                 irq_ack;
    logic                 rom_fetch_start;
    logic                 running;
    logic [7:0]           read_data;
  } result_t;

  localparam int unsigned RES_W       = $bits(result_t);
  localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // cache write request from the access logic
  typedef struct packed {
    logic                   we;
    logic [CACHE_IDX_W-1:0] idx;
    logic [7:0]             data;
  } cache_wr_t;

  function automatic logic [CACHE_IDX_W-1:0] cache_index(input logic [15:0] a);
    logic [15:0] d;
    d = (a - WIN_BASE) & 16'(CACHE_BYTES - 1);
    return d[CACHE_IDX_W-1:0];
  endfunction

  function automatic logic [LINE_W-1:0] line_of(input logic [CACHE_IDX_W-1:0] idx);
    logic [15:0] w;
    w = 16'(idx);
    return w[LINE_W+3:4];
  endfunction

  function automatic logic [3:0] bpp_of(input logic [1:0] cm);
    logic [3:0] b;
    case (cm)
      2'd0:    b = 4'd2;
      2'd1:    b = 4'd4;
      2'd2:    b = 4'd4;
      default: b = 4'd8;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/chri_ram.sv =====
`default_nettype none

module chri_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/chri_core.sv =====
`default_nettype none

module chri_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                commit_i,
  input  wire chri_pkg::item_t     item_i,
  input  wire logic [7:0]          cache_rdata_i,
  output chri_pkg::result_t        res_o,
  output chri_pkg::cache_wr_t      cache_wr_o
);

  import chri_pkg::*;

  logic [15:0]          regs_q [16];
  logic [15:0]          regs_d [16];
  logic [7:0]           latch_q, latch_d;
  logic [3:0]           flags_q, flags_d;
  logic                 go_q, go_d;
  logic                 pend_q, pend_d;
  logic [6:0]           bank_q, bank_d;
  logic                 clksel_q, clksel_d;
  logic [5:0]           mode_q, mode_d;
  logic [7:0]           sbase_q, sbase_d;
  logic [NUM_LINES-1:0] lv_q, lv_d;

  logic [15:0]            addr;
  logic                   in_regs;
  logic                   in_win;
  logic [3:0]             ridx;
  logic [CACHE_IDX_W-1:0] cidx;
  logic [7:0]             status_lo;
  logic [7:0]             rd;
  logic                   fetch;
  logic                   ack;

  assign addr      = item_i.addr;
  assign in_regs   = (addr >= REG_FIRST) && (addr <= REG_LAST);
  assign in_win    = (addr >= WIN_BASE) && (addr <= WIN_LAST);
  assign ridx      = addr[4:1];
  assign cidx      = cache_index(addr);
  assign status_lo = {1'b0, pend_q, go_q, flags_q, 1'b0};

  // decode of one access against the current state
  always_comb begin
    regs_d     = regs_q;
    latch_d    = latch_q;
    flags_d    = flags_q;
    go_d       = go_q;
    pend_d     = pend_q;
    bank_d     = bank_q;
    clksel_d   = clksel_q;
    mode_d     = mode_q;
    sbase_d    = sbase_q;
    lv_d       = lv_q;
    rd         = '0;
    fetch      = 1'b0;
    ack        = 1'b0;
    cache_wr_o = '0;
    unique case (item_i.op)
      OP_READ: begin
        if (!(go_q && addr != ADDR_STATUS_LO && addr != ADDR_STATUS_HI
              && addr != ADDR_VERSION)) begin
          if (in_regs) begin
            rd = addr[0] ? regs_q[ridx][15:8] : regs_q[ridx][7:0];
          end else begin
            unique case (addr)
              ADDR_STATUS_LO: rd = status_lo;
              ADDR_STATUS_HI: ack = 1'b1;
              ADDR_BANK:      rd = {1'b0, bank_q};
              ADDR_VERSION:   rd = VERSION_VAL;
              default: begin
                if (in_win) begin
                  rd = cache_rdata_i;
                end
              end
            endcase
          end
        end
      end
      OP_WRITE: begin
        if (!(go_q && addr != ADDR_STATUS_LO && addr != ADDR_MODE)) begin
          if (in_regs) begin
            if (!addr[0]) begin
              latch_d = item_i.data;
            end else begin
              regs_d[ridx] = {item_i.data, latch_q};
              if (ridx == REG_ROM_FETCH) begin
                pend_d = 1'b1;
                fetch  = 1'b1;
              end else if (ridx == REG_GO) begin
                go_d = 1'b1;
              end
            end
          end else begin
            unique case (addr)
              ADDR_STATUS_LO: begin
                flags_d = item_i.data[4:1];
                go_d    = item_i.data[5];
                if (go_q && !item_i.data[5]) begin
                  lv_d = '0;
                end
              end
              ADDR_BANK: begin
                bank_d = item_i.data[6:0];
                lv_d   = '0;
              end
              ADDR_SCREEN: sbase_d  = item_i.data;
              ADDR_CLKSEL: clksel_d = item_i.data[0];
              ADDR_MODE:   mode_d   = item_i.data[5:0];
              default: begin
                if (in_win) begin
                  cache_wr_o.we   = 1'b1;
                  cache_wr_o.idx  = cidx;
                  cache_wr_o.data = item_i.data;
                  if (cidx[3:0] == 4'hF) begin
                    lv_d = lv_q | (NUM_LINES'(1) << line_of(cidx));
                  end
                end
              end
            endcase
          end
        end
      end
      OP_FILL_DONE: pend_d = 1'b0;
      default: ;
    endcase
  end

  // result reflects the state after the access
  always_comb begin
    res_o.read_data       = rd;
    res_o.running         = go_d;
    res_o.rom_fetch_start = fetch;
    res_o.irq_ack         = ack;
    res_o.valid_lines     = lv_d;
    res_o.plot_bpp        = bpp_of(mode_d[1:0]);
    res_o.screen_height   = {mode_d[5], mode_d[2]};
    res_o.ram_granted     = mode_d[3];
    res_o.rom_granted     = mode_d[4];
    res_o.program_bank    = bank_d;
    res_o.clock_select    = clksel_d;
    res_o.screen_base     = sbase_d;
  end

  // state update when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        regs_q[i] <= '0;
      end
      latch_q  <= '0;
      flags_q  <= '0;
      go_q     <= 1'b0;
      pend_q   <= 1'b0;
      bank_q   <= '0;
      clksel_q <= 1'b0;
      mode_q   <= '0;
      sbase_q  <= '0;
      lv_q     <= '0;
    end else if (commit_i) begin
      regs_q   <= regs_d;
      latch_q  <= latch_d;
      flags_q  <= flags_d;
      go_q     <= go_d;
      pend_q   <= pend_d;
      bank_q   <= bank_d;
      clksel_q <= clksel_d;
      mode_q   <= mode_d;
      sbase_q  <= sbase_d;
      lv_q     <= lv_d;
    end
  end

  // a rom fetch start is only possible while stopped, and it does not start
  a_fetch_not_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.rom_fetch_start |-> !res_o.running)
    else $error("rom fetch started while running");

  // interrupt acknowledge returns a zero byte
  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.irq_ack |-> (res_o.read_data == 8'h00 && item_i.op == OP_READ))
    else $error("irq ack with non-zero data or on a non-read");

  // cache is written only from an ungated host write
  a_wr_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cache_wr_o.we |-> (item_i.op == OP_WRITE && !go_q))
    else $error("cache write outside an ungated host write");

endmodule

`default_nettype wire

// ===== rtl/coprocessor_host_register_interface_top.sv =====
`default_nettype none

// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   address[15:0], write_data[23:16]            opcode[1:0]
// m_axis    out  read_data, running, rom_fetch_start,         -
//                irq_ack, valid_lines, plot_bpp, screen_height,
//                ram_granted, rom_granted, program_bank,
//                clock_select, screen_base, zero pad to 72 bits
//
// one item per cycle sustained while m_axis_tready_i is high; each item
// passes through the input register (cache byte read) and then sits in the result register.
// after reset the program cache is cleared, one byte a cycle, with
// s_axis_tready_o low, and no item taken, until the sweep is done.
// a stalled result register holds the input register; once clearing is
// done, input is taken whenever the input register is empty or moving on.

module coprocessor_host_register_interface_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // address[15:0], write_data[23:16]
  input  wire logic [23:0]                           s_axis_tdata_i,
  // opcode[1:0]
  input  wire logic [1:0]                            s_axis_tuser_i,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // read_data[7:0], running[8], rom_fetch_start[9], irq_ack[10],
  // valid_lines[42:11], plot_bpp[46:43], screen_height[48:47],
  // ram_granted[49], rom_granted[50], program_bank[57:51],
  // clock_select[58], screen_base[66:59], zero[71:67]
  output logic [chri_pkg::OUT_TDATA_W-1:0]           m_axis_tdata_o
);

  import chri_pkg::*;

  logic                   clearing_q, clearing_d;
  logic [CACHE_IDX_W-1:0] clr_cnt_q, clr_cnt_d;

  logic                   s1_valid_q, s1_valid_d;
  item_t                  s1_item_q;
  item_t                  in_item;
  logic                   accept;
  logic                   s1_adv;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic                   fwd_hit_q;
  logic [7:0]             fwd_data_q;
  logic [7:0]             ram_rdata;
  logic [7:0]             cache_rdata;
  logic [CACHE_IDX_W-1:0] in_idx;

  result_t                res;
  cache_wr_t              cache_wr;

  logic                   ram_we;
  logic [CACHE_IDX_W-1:0] ram_waddr;
  logic [7:0]             ram_wdata;

  // input item unpacking
  assign in_item.op   = op_e'(s_axis_tuser_i);
  assign in_item.addr = s_axis_tdata_i[15:0] & ADDR_MASK;
  assign in_item.data = s_axis_tdata_i[23:16];
  assign in_idx       = cache_index(in_item.addr);

  // handshake
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !clearing_q && (!s1_valid_q || s1_adv);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // cache clearing pass after reset
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == CACHE_IDX_W'(CACHE_BYTES - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  // cache write port: clearing sweep or committed host write
  assign ram_we    = clearing_q || (cache_wr.we && s1_adv);
  assign ram_waddr = clearing_q ? clr_cnt_q : cache_wr.idx;
  assign ram_wdata = clearing_q ? 8'h00 : cache_wr.data;

  chri_ram #(
    .WIDTH (8),
    .DEPTH (CACHE_BYTES)
  ) u_cache (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // byte written in the same cycle as the read is forwarded
  assign cache_rdata = fwd_hit_q ? fwd_data_q : ram_rdata;

  chri_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .commit_i      (s1_adv),
    .item_i        (s1_item_q),
    .cache_rdata_i (cache_rdata),
    .res_o         (res),
    .cache_wr_o    (cache_wr)
  );

  // pipeline valids
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        fwd_hit_q <= cache_wr.we && s1_adv && (cache_wr.idx == in_idx);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q  <= in_item;
      fwd_data_q <= cache_wr.data;
    end
    if (s1_adv) begin
      out_data_q <= OUT_TDATA_W'(res);
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready_o)
    else $error("input ready during cache clearing");

  a_empty_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s1_valid_q && !out_valid_q))
    else $error("item in flight during cache clearing");

  a_fwd_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_hit_q) |-> $past(s1_adv && cache_wr.we))
    else $error("cache forward without a committed write");

  a_ready_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && s1_valid_q && out_valid_q) |-> m_axis_tready_i)
    else $error("input ready with both registers full and output stalled");

endmodule

`default_nettype wire
